// File: src/sgs_pkg.sv
// ----------------------------------------------------------------------------
// sgs_pkg
// Shared types, constants and the gain table generator for the smoothed
// decibel gain stage.
// ----------------------------------------------------------------------------
package sgs_pkg;

  // Field widths fixed by the interface
  localparam int GAIN_W  = 22;
  localparam int PARAM_W = 18;
  localparam int COEFF_W = 16;
  localparam int FUNC_W  = 2;
  localparam int LEVEL_W = 16;

  // Parameter defaults
  localparam int TABLE_BITS_DEF  = 10;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int QUEUE_DEPTH     = 2;

  // Reset values
  localparam logic [COEFF_W-1:0]        COEFF_RST   = 16'd91;
  localparam logic signed [PARAM_W-1:0] SETTING_RST = 18'sd54613;
  localparam logic signed [PARAM_W-1:0] MOD_RST     = '0;
  localparam logic [GAIN_W-1:0]         UNITY_GAIN  = 22'd1048576;
  localparam logic [GAIN_W-1:0]         GAIN_MAX    = 22'h3FFFFF;

  // Fixed point shifts
  localparam int SMOOTH_SHIFT = 16;
  localparam int SCALE_SHIFT  = 20;

  // Item selector codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_FRAME = 2'd0,
    FUNC_GAIN  = 2'd1,
    FUNC_MOD   = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // Queue entry kinds
  typedef enum logic {
    OP_FRAME  = 1'b0,
    OP_TARGET = 1'b1
  } op_kind_t;

  // Back end sequencer
  typedef enum logic [2:0] {
    BS_IDLE,
    BS_ROM,
    BS_SMOOTH,
    BS_SCALE,
    BS_SAT
  } back_state_t;

  // Queue handshake between front and back
  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctl_t;

  // Gain table entry k: round(2^20 * 10^((-60 + k*step)/20)), capped.
  // Evaluated at elaboration only.
  function automatic logic [GAIN_W-1:0] gain_entry(int k, real db_step);
    real db;
    real lin;
    db  = -60.0 + db_step * real'(k);
    lin = 1048576.0 * (10.0 ** (db / 20.0));
    if (lin + 0.5 >= 4194304.0) begin
      return GAIN_MAX;
    end
    return GAIN_W'($rtoi(lin + 0.5));
  endfunction

endpackage

// File: src/sgs_queue.sv
// ----------------------------------------------------------------------------
// sgs_queue
// Small register FIFO between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module sgs_queue
  import sgs_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  queue_ctl_t       ctl,
  input  logic [WIDTH-1:0] wr_data,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = ctl.push && !full;
  assign do_pop    = ctl.pop && not_empty;
  assign rd_data   = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: src/sgs_gain_rom.sv
// ----------------------------------------------------------------------------
// sgs_gain_rom
// Decibel-to-linear gain table, -60 dB to +12 dB, Q2.20, registered read.
// ----------------------------------------------------------------------------
module sgs_gain_rom
  import sgs_pkg::*;
#(
  parameter int TABLE_BITS = TABLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [TABLE_BITS-1:0] addr,
  output logic [GAIN_W-1:0]     data
);

  localparam int  ROM_DEPTH = 1 << TABLE_BITS;
  localparam real DB_STEP   = 72.0 / real'(ROM_DEPTH - 1);

  logic [GAIN_W-1:0] rom_tbl [ROM_DEPTH];

  // Table contents fixed at elaboration
  for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_entry
    assign rom_tbl[k] = gain_entry(k, DB_STEP);
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      data <= rom_tbl[addr];
    end
  end

endmodule

// File: src/sgs_front.sv
// ----------------------------------------------------------------------------
// sgs_front
// Accepts items, tracks gain and modulation, and queues either a table
// index for a new target or a stereo frame.
// ----------------------------------------------------------------------------
module sgs_front
  import sgs_pkg::*;
#(
  parameter int TABLE_BITS  = TABLE_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int Q_W         = 1 + TABLE_BITS + 2 * SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [FUNC_W-1:0]             func,
  input  logic signed [SAMPLE_BITS-1:0] left_in,
  input  logic signed [SAMPLE_BITS-1:0] right_in,
  input  logic signed [PARAM_W-1:0]     param_value,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [Q_W-1:0]                q_data
);

  logic signed [PARAM_W-1:0] gain_setting;
  logic signed [PARAM_W-1:0] mod_amount;

  logic                      accept;
  func_t                     fsel;
  logic signed [PARAM_W-1:0] gain_next;
  logic signed [PARAM_W-1:0] mod_next;
  logic signed [PARAM_W:0]   level_sum;
  logic [LEVEL_W-1:0]        level;
  logic [TABLE_BITS-1:0]     idx;
  op_kind_t                  kind;

  assign fsel     = func_t'(func);
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Settings as they stand after this transaction
  always_comb begin
    gain_next = gain_setting;
    mod_next  = mod_amount;
    case (fsel)
      FUNC_GAIN: gain_next = param_value;
      FUNC_MOD:  mod_next  = param_value;
      default:   ;
    endcase
  end

  // Clamp the sum to 0..65535 and take the table index from its top bits
  always_comb begin
    level_sum = {gain_next[PARAM_W-1], gain_next} + {mod_next[PARAM_W-1], mod_next};
    if (level_sum[PARAM_W]) begin
      level = '0;
    end else if (level_sum[PARAM_W-1:LEVEL_W] != '0) begin
      level = '1;
    end else begin
      level = level_sum[LEVEL_W-1:0];
    end
    idx = level[LEVEL_W-1 -: TABLE_BITS];
  end

  // Classify; the reserved selector is dropped
  assign kind   = (fsel == FUNC_FRAME) ? OP_FRAME : OP_TARGET;
  assign q_push = accept && (fsel != FUNC_NONE);
  assign q_data = {kind, idx, left_in, right_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_setting <= SETTING_RST;
      mod_amount   <= MOD_RST;
    end else if (accept) begin
      gain_setting <= gain_next;
      mod_amount   <= mod_next;
    end
  end

endmodule

// File: src/sgs_back.sv
// ----------------------------------------------------------------------------
// sgs_back
// Executes queued operations: target updates through the gain table, and
// per-frame one-pole smoothing followed by sample scaling and saturation.
// ----------------------------------------------------------------------------
module sgs_back
  import sgs_pkg::*;
#(
  parameter int TABLE_BITS  = TABLE_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int Q_W         = 1 + TABLE_BITS + 2 * SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [COEFF_W-1:0]            cfg_coeff,
  input  logic                          q_not_empty,
  input  logic [Q_W-1:0]                q_data,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out,
  output logic [GAIN_W-1:0]             gain_now
);

  localparam int DIFF_W  = GAIN_W + 1;
  localparam int SPROD_W = COEFF_W + 1 + DIFF_W;
  localparam int PROD_W  = SAMPLE_BITS + GAIN_W + 1;
  localparam int SUM_W   = GAIN_W + 2;

  // Queue entry fields
  op_kind_t                      q_kind;
  logic [TABLE_BITS-1:0]         q_idx;
  logic signed [SAMPLE_BITS-1:0] q_left;
  logic signed [SAMPLE_BITS-1:0] q_right;

  assign q_kind  = op_kind_t'(q_data[Q_W-1]);
  assign q_idx   = q_data[Q_W-2 -: TABLE_BITS];
  assign q_left  = q_data[2*SAMPLE_BITS-1 -: SAMPLE_BITS];
  assign q_right = q_data[SAMPLE_BITS-1:0];

  back_state_t state;
  back_state_t state_next;

  logic [COEFF_W-1:0]            coeff;
  logic [GAIN_W-1:0]             target;
  logic [GAIN_W-1:0]             current;
  logic signed [SPROD_W-1:0]     step_prod;
  logic signed [SAMPLE_BITS-1:0] left_s;
  logic signed [SAMPLE_BITS-1:0] right_s;
  logic signed [PROD_W-1:0]      prod_l;
  logic signed [PROD_W-1:0]      prod_r;

  logic                          rom_en;
  logic [GAIN_W-1:0]             rom_data;
  logic                          out_free;
  logic                          load_out;
  logic                          take_frame;

  logic signed [DIFF_W-1:0]      diff;
  logic signed [SPROD_W-1:0]     step_shift;
  logic signed [SUM_W-1:0]       cur_sum;
  logic [GAIN_W-1:0]             current_next;
  logic signed [PROD_W-1:0]      sh_l;
  logic signed [PROD_W-1:0]      sh_r;
  logic signed [SAMPLE_BITS-1:0] sat_l;
  logic signed [SAMPLE_BITS-1:0] sat_r;

  sgs_gain_rom #(
    .TABLE_BITS (TABLE_BITS)
  ) u_rom (
    .clk   (clk),
    .rd_en (rom_en),
    .addr  (q_idx),
    .data  (rom_data)
  );

  assign out_free = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      BS_IDLE: begin
        if (q_not_empty) begin
          state_next = (q_kind == OP_TARGET) ? BS_ROM : BS_SMOOTH;
        end
      end
      BS_ROM:    state_next = BS_IDLE;
      BS_SMOOTH: state_next = BS_SCALE;
      BS_SCALE:  state_next = BS_SAT;
      BS_SAT: begin
        if (out_free) begin
          state_next = BS_IDLE;
        end
      end
      default:   state_next = BS_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop      = 1'b0;
    rom_en     = 1'b0;
    take_frame = 1'b0;
    load_out   = 1'b0;
    case (state)
      BS_IDLE: begin
        q_pop      = q_not_empty;
        rom_en     = q_not_empty && (q_kind == OP_TARGET);
        take_frame = q_not_empty && (q_kind == OP_FRAME);
      end
      BS_SAT:  load_out = out_free;
      default: ;
    endcase
  end

  // One-pole step: current + floor(coeff*(target-current) / 2^16), clamped
  always_comb begin
    diff       = $signed({1'b0, target}) - $signed({1'b0, current});
    step_shift = step_prod >>> SMOOTH_SHIFT;
    cur_sum    = $signed({2'b00, current}) + SUM_W'(step_shift);
    if (cur_sum[SUM_W-1]) begin
      current_next = '0;
    end else if (cur_sum[SUM_W-2]) begin
      current_next = GAIN_MAX;
    end else begin
      current_next = cur_sum[GAIN_W-1:0];
    end
  end

  // Scale and saturate to the sample range
  always_comb begin
    sh_l = prod_l >>> SCALE_SHIFT;
    sh_r = prod_r >>> SCALE_SHIFT;
    if (sh_l[PROD_W-1:SAMPLE_BITS-1] == '0 || sh_l[PROD_W-1:SAMPLE_BITS-1] == '1) begin
      sat_l = sh_l[SAMPLE_BITS-1:0];
    end else begin
      sat_l = {sh_l[PROD_W-1], {(SAMPLE_BITS-1){~sh_l[PROD_W-1]}}};
    end
    if (sh_r[PROD_W-1:SAMPLE_BITS-1] == '0 || sh_r[PROD_W-1:SAMPLE_BITS-1] == '1) begin
      sat_r = sh_r[SAMPLE_BITS-1:0];
    end else begin
      sat_r = {sh_r[PROD_W-1], {(SAMPLE_BITS-1){~sh_r[PROD_W-1]}}};
    end
  end

  // Control and gain state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BS_IDLE;
      coeff     <= COEFF_RST;
      target    <= UNITY_GAIN;
      current   <= UNITY_GAIN;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        coeff <= cfg_coeff;
      end
      if (state == BS_ROM) begin
        target <= rom_data;
      end
      if (state == BS_SMOOTH) begin
        current <= current_next;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (take_frame) begin
      left_s    <= q_left;
      right_s   <= q_right;
      step_prod <= $signed({1'b0, coeff}) * diff;
    end
    if (state == BS_SCALE) begin
      prod_l <= left_s * $signed({1'b0, current});
      prod_r <= right_s * $signed({1'b0, current});
    end
    if (load_out) begin
      left_out  <= sat_l;
      right_out <= sat_r;
      gain_now  <= current;
    end
  end

endmodule

// File: src/smoothed_db_gain_stage_core.sv
// ----------------------------------------------------------------------------
// smoothed_db_gain_stage_core
// Stereo gain stage with decibel-mapped target and one-pole smoothing.
// ----------------------------------------------------------------------------
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+--------------------
//  in      | func, left_in, right_in, param_value      | in_valid / in_stall
//  out     | left_out, right_out, gain_now             | out_valid/out_stall
//  cfg     | cfg_data (smoothing coefficient)          | cfg_valid/cfg_ready
//
//  The front takes one transaction per cycle while the two-entry queue has
//  room. The back sequencer steps through the product of the smoothing step,
//  gain update, sample multiply and saturate for each stereo frame, and
//  through a registered table read for each gain or modulation change; that
//  sequencer sets the sustained rate. Reset is synchronous; it restores unity
//  gain, 0 dB setting, zero modulation and coefficient 91. A stalled output
//  holds the back in its last step; the front keeps filling the queue meanwhile.
// ----------------------------------------------------------------------------
module smoothed_db_gain_stage_core
  import sgs_pkg::*;
#(
  parameter int TABLE_BITS  = TABLE_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // input transactions
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [FUNC_W-1:0]             func,
  input  logic signed [SAMPLE_BITS-1:0] left_in,
  input  logic signed [SAMPLE_BITS-1:0] right_in,
  input  logic signed [PARAM_W-1:0]     param_value,
  // result transactions
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out,
  output logic [GAIN_W-1:0]             gain_now,
  // configuration write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [COEFF_W-1:0]            cfg_data
);

  localparam int Q_W = 1 + TABLE_BITS + 2 * SAMPLE_BITS;

  queue_ctl_t       q_ctl;
  logic             q_push;
  logic             q_pop;
  logic [Q_W-1:0]   q_wr_data;
  logic [Q_W-1:0]   q_rd_data;
  logic             q_full;
  logic             q_not_empty;
  logic             cfg_we;

  // Configuration is always taken
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // Queue control from front push and back pop
  assign q_ctl = '{push: q_push, pop: q_pop};

  sgs_front #(
    .TABLE_BITS  (TABLE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .Q_W         (Q_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .left_in     (left_in),
    .right_in    (right_in),
    .param_value (param_value),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wr_data)
  );

  sgs_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .ctl       (q_ctl),
    .wr_data   (q_wr_data),
    .rd_data   (q_rd_data),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  sgs_back #(
    .TABLE_BITS  (TABLE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .Q_W         (Q_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_coeff   (cfg_data),
    .q_not_empty (q_not_empty),
    .q_data      (q_rd_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .left_out    (left_out),
    .right_out   (right_out),
    .gain_now    (gain_now)
  );

endmodule
